// File: rtl/top_k_score_select_macros.svh
// Assertion macros for the top-k score selector.
// Used by tkss_ctrl and top_k_score_select; clocks on clk, resets on rst_n.
`ifndef TOP_K_SCORE_SELECT_MACROS_SVH
`define TOP_K_SCORE_SELECT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define TKSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define TKSS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TKSS_ASSERT_IMP(label, ante, cons, msg)
`define TKSS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/tkss_pkg.sv
// Shared constants, types and sequencer states of the top-k score selector.
// No dependencies; imported by tkss_ctrl, top_k_score_select and the testbench.
package tkss_pkg;

    localparam int MAX_ITEMS = 512;
    localparam int TOP_COUNT = 5;

    localparam int SW    = 32;                      // score width
    localparam int IDX_W = 9;                       // item_index port width
    localparam int AW    = $clog2(MAX_ITEMS);       // store address width
    localparam int CW    = $clog2(MAX_ITEMS + 1);   // fill count width
    localparam int PSW   = CW + 1;                  // signed scan pointer width

    localparam logic [CW-1:0]         TOP_CW   = CW'(TOP_COUNT);
    localparam logic [CW-1:0]         FULL_CW  = CW'(MAX_ITEMS);
    localparam logic signed [PSW-1:0] ZERO_POS = '0;
    localparam logic signed [PSW-1:0] ONE_POS  = PSW'(1);
    localparam logic signed [PSW-1:0] K_POS    = PSW'(TOP_COUNT - 1);

    typedef struct packed {
        logic signed [SW-1:0] score;
        logic [AW-1:0]        pos;
    } entry_t;

    localparam int EW = $bits(entry_t);

    typedef struct packed {
        logic          rd_en;
        logic [AW-1:0] rd_addr;
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        entry_t        wr_data;
    } mem_req_t;

    typedef struct packed {
        logic   valid;
        logic   last;
        entry_t data;
    } emit_t;

    typedef enum logic [3:0] {
        SEL_IDLE,
        SEL_ROUND,
        SEL_PIVOT,
        SEL_RDI,
        SEL_SCANI,
        SEL_SCANJ,
        SEL_SWAP,
        SEL_ERD,
        SEL_EOUT
    } sel_state_t;

endpackage

// File: rtl/tkss_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
// Generic; no package dependency.
module tkss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/tkss_ctrl.sv
// Selection sequencer: Hoare quickselect walk over the score RAM, then emit.
// Depends on tkss_pkg and top_k_score_select_macros.svh.
`include "top_k_score_select_macros.svh"
module tkss_ctrl import tkss_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [CW-1:0] count,
    input  entry_t        rd_data,
    output mem_req_t      req,
    output emit_t         emit,
    output logic          active
);

    sel_state_t state_reg, state_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [CW-1:0]         r_reg, r_next;
    logic signed [PSW-1:0] left_reg, left_next;
    logic signed [PSW-1:0] right_reg, right_next;
    logic signed [PSW-1:0] i_reg, i_next;
    logic signed [PSW-1:0] j_reg, j_next;
    logic signed [SW-1:0]  pivot_reg, pivot_next;
    entry_t                a_reg, a_next;

    logic signed [PSW-1:0] n_pos, nm1, i_inc, j_dec;
    logic [CW-1:0]         emit_cnt;
    logic                  emit_last;

    assign n_pos     = $signed({1'b0, n_reg});
    assign nm1       = n_pos - ONE_POS;
    assign i_inc     = i_reg + ONE_POS;
    assign j_dec     = j_reg - ONE_POS;
    assign emit_cnt  = (n_reg < TOP_CW) ? n_reg : TOP_CW;
    assign emit_last = (r_reg == emit_cnt - CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        r_reg     <= r_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        pivot_reg <= pivot_next;
        a_reg     <= a_next;
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        r_next     = r_reg;
        left_next  = left_reg;
        right_next = right_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pivot_next = pivot_reg;
        a_next     = a_reg;
        req        = '0;
        emit       = '0;
        active     = 1'b1;

        case (state_reg)
            SEL_IDLE:
            begin
                active = 1'b0;
                if (go)
                begin
                    n_next     = count;
                    r_next     = '0;
                    left_next  = ZERO_POS;
                    right_next = $signed({1'b0, count}) - ONE_POS;
                    // small sets skip selection and go out in arrival order
                    state_next = (count < TOP_CW) ? SEL_ERD : SEL_ROUND;
                end
            end
            SEL_ROUND:
            begin
                if (left_reg < right_reg)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = K_POS[AW-1:0];
                    state_next  = SEL_PIVOT;
                end
                else
                begin
                    r_next     = '0;
                    state_next = SEL_ERD;
                end
            end
            SEL_PIVOT:
            begin
                pivot_next = rd_data.score;
                i_next     = left_reg;
                j_next     = right_reg;
                state_next = SEL_RDI;
            end
            SEL_RDI:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = i_reg[AW-1:0];
                state_next  = SEL_SCANI;
            end
            SEL_SCANI:
            begin
                req.rd_en = 1'b1;
                if (i_reg < nm1 && rd_data.score > pivot_reg)
                begin
                    i_next      = i_inc;
                    req.rd_addr = i_inc[AW-1:0];
                end
                else
                begin
                    // hold left entry, start the right scan
                    a_next      = rd_data;
                    req.rd_addr = j_reg[AW-1:0];
                    state_next  = SEL_SCANJ;
                end
            end
            SEL_SCANJ:
            begin
                if (j_reg > ZERO_POS && rd_data.score < pivot_reg)
                begin
                    j_next      = j_dec;
                    req.rd_en   = 1'b1;
                    req.rd_addr = j_dec[AW-1:0];
                end
                else if (i_reg >= j_reg)
                begin
                    // partition done: narrow the window around position k
                    if (i_reg <= K_POS)
                    begin
                        left_next = j_reg + ONE_POS;
                    end
                    if (K_POS <= j_reg)
                    begin
                        right_next = i_reg - ONE_POS;
                    end
                    state_next = SEL_ROUND;
                end
                else
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = i_reg[AW-1:0];
                    req.wr_data = rd_data;
                    state_next  = SEL_SWAP;
                end
            end
            SEL_SWAP:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = j_reg[AW-1:0];
                req.wr_data = a_reg;
                i_next      = i_inc;
                j_next      = j_dec;
                state_next  = SEL_RDI;
            end
            SEL_ERD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = r_reg[AW-1:0];
                state_next  = SEL_EOUT;
            end
            SEL_EOUT:
            begin
                emit.valid = 1'b1;
                emit.last  = emit_last;
                emit.data  = rd_data;
                if (emit_last)
                begin
                    state_next = SEL_IDLE;
                end
                else
                begin
                    r_next     = r_reg + CW'(1);
                    state_next = SEL_ERD;
                end
            end
            default:
            begin
                state_next = SEL_IDLE;
            end
        endcase
    end

    `TKSS_ASSERT_IMP(a_no_rw_clash, req.rd_en && req.wr_en, req.rd_addr != req.wr_addr,
        "read and write hit the same entry in one cycle")
    `TKSS_ASSERT_IMP(a_go_idle, go, state_reg == SEL_IDLE,
        "new set closed while selection still running")
    `TKSS_ASSERT_IMP(a_i_range, state_reg == SEL_SCANI, i_reg >= ZERO_POS && i_reg < n_pos,
        "left scan pointer left the loaded range")
    `TKSS_ASSERT_IMP(a_j_range, state_reg == SEL_SCANJ, j_reg >= ZERO_POS && j_reg < n_pos,
        "right scan pointer left the loaded range")

endmodule

// File: rtl/top_k_score_select.sv
// Top level of the top-k score selector: load counter, RAM port mux, result registers.
// Depends on tkss_pkg, tkss_ram, tkss_ctrl and top_k_score_select_macros.svh.
//
// Usage:
//   Input beats: drive score and last_score with start high; a beat is taken
//   at a clock edge where start is high and busy is low. Loading takes one
//   beat per cycle while busy is low. Each score is stored with its arrival
//   position as index; beyond MAX_ITEMS scores further ones are dropped, but
//   last_score still closes the set.
//   A beat with last_score high closes the set. busy rises on the next cycle
//   while a quickselect walk runs over the score RAM (one RAM read port, one
//   write port): each scan step reads one entry, each swap writes two and
//   each round reads its pivot; the walk is data-dependent, O(n) typical, O(n^2) worst.
//   Sets smaller than TOP_COUNT skip the walk and go out in arrival order.
//   Result beats: min(n, TOP_COUNT) results, each read from the RAM first and
//   shown for exactly one cycle with result_strobe high; last_result marks the
//   final one. The receiver cannot stall. busy falls with the final strobe.
//   Reset: asynchronous, active low; clears the fill count and sequencer.
//   The score RAM needs no clearing: only entries of the current set are read.
`include "top_k_score_select_macros.svh"
module top_k_score_select import tkss_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [SW-1:0] score,
    input  logic                 last_score,
    output logic                 result_strobe,
    output logic [IDX_W-1:0]     item_index,
    output logic signed [SW-1:0] item_score,
    output logic                 last_result
);

    logic [CW-1:0]        count_reg, count_next;
    logic                 strobe_reg;
    logic [IDX_W-1:0]     index_reg;
    logic signed [SW-1:0] score_reg;
    logic                 last_reg;

    logic     accept, room, go, ctrl_active;
    logic     ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t   ram_wdata;
    logic [EW-1:0] ram_rdata;
    entry_t   rd_entry;
    mem_req_t req;
    emit_t    emit;

    assign busy   = ctrl_active;
    assign accept = start && !busy;
    assign room   = (count_reg < FULL_CW);
    assign go     = accept && last_score;

    // advance the fill count on stored beats, restart it when a set closes
    always_comb
    begin
        count_next = count_reg;
        if (go)
        begin
            count_next = '0;
        end
        else if (accept && room)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            strobe_reg <= emit.valid;
        end
    end

    // result payload; no reset needed, qualified by the strobe
    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            index_reg <= IDX_W'(emit.data.pos);
            score_reg <= emit.data.score;
            last_reg  <= emit.last;
        end
    end

    // loading owns the write port while the sequencer is idle
    always_comb
    begin
        if (accept && room)
        begin
            ram_we          = 1'b1;
            ram_waddr       = count_reg[AW-1:0];
            ram_wdata.score = score;
            ram_wdata.pos   = count_reg[AW-1:0];
        end
        else
        begin
            ram_we    = req.wr_en;
            ram_waddr = req.wr_addr;
            ram_wdata = req.wr_data;
        end
    end

    assign rd_entry = entry_t'(ram_rdata);

    tkss_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_ITEMS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (req.rd_en),
        .raddr(req.rd_addr),
        .rdata(ram_rdata)
    );

    tkss_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .count  (count_reg + CW'(room)),
        .rd_data(rd_entry),
        .req    (req),
        .emit   (emit),
        .active (ctrl_active)
    );

    assign result_strobe = strobe_reg;
    assign item_index    = index_reg;
    assign item_score    = score_reg;
    assign last_result   = last_reg;

    `TKSS_ASSERT_NXT(a_strobe_gap, strobe_reg, !strobe_reg,
        "two result beats in back-to-back cycles")
    `TKSS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= FULL_CW,
        "fill count beyond store depth")
    `TKSS_ASSERT_IMP(a_port_owner, accept && room, !req.wr_en,
        "load and selection both drive the write port")

endmodule

// File: tb/sv/tkss_result_checker.sv
// Result checker for the top-k score selector: predicts each selected entry and compares.
// Depends on tkss_pkg for widths and sizes. It is instantiated by top_k_score_select_test.
`timescale 1ns / 1ps
module tkss_result_checker import tkss_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic signed [SW-1:0] score,
    input  logic                 last_score,
    input  logic                 result_strobe,
    input  logic [IDX_W-1:0]     item_index,
    input  logic signed [SW-1:0] item_score,
    input  logic                 last_result,
    output int                   mismatch_count,
    output int                   waiting_results,
    output int                   checked_results
);

    typedef struct packed {
        logic [IDX_W-1:0]     index;
        logic signed [SW-1:0] value;
        logic                 closing;
    } ranked_entry_t;

    // Predicted contents of the score RAM for the set being loaded.
    logic signed [SW-1:0] set_score [MAX_ITEMS];
    logic [AW-1:0]        set_pos   [MAX_ITEMS];
    int                   set_fill;
    ranked_entry_t        ranked_q[$];

    // Hoare quickselect, descending, pivot taken at position TOP_COUNT-1 each round.
    function automatic void partition_top(input int n);
        int                   k;
        int                   lo;
        int                   hi;
        int                   i;
        int                   j;
        logic signed [SW-1:0] pivot;
        logic signed [SW-1:0] keep_score;
        logic [AW-1:0]        keep_pos;
        k  = TOP_COUNT - 1;
        lo = 0;
        hi = n - 1;
        while (lo < hi)
        begin
            pivot = set_score[k];
            i = lo;
            j = hi;
            while (1)
            begin
                while (i < n - 1 && set_score[i] > pivot)
                    i++;
                while (j > 0 && set_score[j] < pivot)
                    j--;
                if (i >= j)
                    break;
                // swap score and index together
                keep_score   = set_score[i];
                keep_pos     = set_pos[i];
                set_score[i] = set_score[j];
                set_pos[i]   = set_pos[j];
                set_score[j] = keep_score;
                set_pos[j]   = keep_pos;
                i++;
                j--;
            end
            if (i <= k)
                lo = j + 1;
            if (k <= j)
                hi = i - 1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        ranked_entry_t want;
        int            emit;
        int            r;
        if (!rst_n)
        begin
            set_fill        = 0;
            mismatch_count  = 0;
            checked_results = 0;
            ranked_q.delete();
        end
        else
        begin
            // Compare results first: a new set's first beat can land on the final strobe.
            if (result_strobe)
            begin
                if (ranked_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected (index %0d score %0d)",
                             $time, item_index, item_score);
                    mismatch_count++;
                end
                else
                begin
                    want = ranked_q.pop_front();
                    checked_results++;
                    if (item_index !== want.index)
                    begin
                        $display("%0t: item_index expected %0d actual %0d",
                                 $time, want.index, item_index);
                        mismatch_count++;
                    end
                    if (item_score !== want.value)
                    begin
                        $display("%0t: item_score expected %0d actual %0d",
                                 $time, want.value, item_score);
                        mismatch_count++;
                    end
                    if (last_result !== want.closing)
                    begin
                        $display("%0t: last_result expected %0b actual %0b",
                                 $time, want.closing, last_result);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (set_fill < MAX_ITEMS)
                begin
                    set_score[set_fill] = score;
                    set_pos[set_fill]   = AW'(set_fill);
                    set_fill++;
                end
                if (last_score)
                begin
                    if (set_fill >= TOP_COUNT)
                    begin
                        partition_top(set_fill);
                        emit = TOP_COUNT;
                    end
                    else
                    begin
                        emit = set_fill;
                    end
                    for (r = 0; r < emit; r++)
                    begin
                        want.index   = IDX_W'(set_pos[r]);
                        want.value   = set_score[r];
                        want.closing = (r == emit - 1);
                        ranked_q.push_back(want);
                    end
                    set_fill = 0;
                end
            end
        end
        waiting_results = ranked_q.size();
    end

endmodule

// File: tb/sv/top_k_score_select_test.sv
// Testbench top for the top-k score selector: clock, reset, score beats and verdict.
// Depends on tkss_pkg, top_k_score_select and tkss_result_checker.
`timescale 1ns / 1ps
module top_k_score_select_test;
    import tkss_pkg::*;

    // Content shapes for a random set: full range, narrow (many ties),
    // mostly field extremes, and whole Q16.16 values with heavy ties.
    typedef enum int {
        SPREAD_WIDE,
        SPREAD_NARROW,
        SPREAD_EDGES,
        SPREAD_TIES
    } score_spread_t;

    localparam logic signed [SW-1:0] SCORE_MIN = 32'sh8000_0000;
    localparam logic signed [SW-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SW-1:0] Q_ONE     = 32'sh0001_0000;
    localparam int RANDOM_BEATS  = 420;
    localparam int OVERFILL      = 3;   // beats pushed past a full store
    localparam int DRAIN_CYCLES  = 40;  // quiet time after the last result

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [SW-1:0] score;
    logic                 last_score;
    logic                 result_strobe;
    logic [IDX_W-1:0]     item_index;
    logic signed [SW-1:0] item_score;
    logic                 last_result;

    int mismatch_count;
    int waiting_results;
    int checked_results;

    // Scores of the next set, sent in order with last_score on the final beat.
    logic signed [SW-1:0] set_plan[$];
    bit                   steady;      // no sender gaps for the current set
    int                   beats_sent;
    int                   sets_closed;

    always #5 clk = ~clk;

    top_k_score_select u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .score         (score),
        .last_score    (last_score),
        .result_strobe (result_strobe),
        .item_index    (item_index),
        .item_score    (item_score),
        .last_result   (last_result)
    );

    tkss_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .score           (score),
        .last_score      (last_score),
        .result_strobe   (result_strobe),
        .item_index      (item_index),
        .item_score      (item_score),
        .last_result     (last_result),
        .mismatch_count  (mismatch_count),
        .waiting_results (waiting_results),
        .checked_results (checked_results)
    );

    // Offer one beat and hold it until the block takes it. Before the beat,
    // idle start for a random gap: mostly none, some short, a few long. While
    // start is low, scramble score and last_score; the block must ignore them.
    // With no gap, start stays high straight across beats, and across a busy
    // phase when a new set follows a closed one.
    task automatic send_beat(input logic signed [SW-1:0] value, input logic closing);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            gap = 0;
        else if (roll < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            @(negedge clk);
            start      <= 1'b0;
            score      <= $urandom;
            last_score <= 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start      <= 1'b1;
        score      <= value;
        last_score <= closing;
        // The beat goes in at the first rising edge that sees busy low.
        do
        begin
            @(posedge clk);
        end
        while (busy);
        beats_sent++;
    endtask

    // Send the planned set and empty the plan.
    task automatic send_plan();
        int i;
        for (i = 0; i < set_plan.size(); i++)
            send_beat(set_plan[i], i == set_plan.size() - 1);
        set_plan.delete();
        sets_closed++;
    endtask

    initial
    begin : stimulus
        int            i;
        int            len;
        int            roll;
        int            random_beats;
        score_spread_t spread;
        logic signed [SW-1:0] value;

        // Hold every input known from time zero; reset once, then release it.
        rst_n        = 1'b0;
        start        = 1'b0;
        score        = '0;
        last_score   = 1'b0;
        beats_sent   = 0;
        sets_closed  = 0;
        random_beats = 0;
        steady       = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: a one-score set holding the top extreme.
        set_plan.push_back(SCORE_MAX);
        send_plan();

        // Directed: fewer scores than TOP_COUNT go out in arrival order.
        set_plan.push_back(SCORE_MIN);
        set_plan.push_back(-32'sd1);
        set_plan.push_back(32'sd0);
        set_plan.push_back(SCORE_MAX);
        send_plan();

        // Directed: exactly TOP_COUNT scores, with a repeated value.
        steady = 1'b1;
        set_plan.push_back(32'sd3);
        set_plan.push_back(SCORE_MAX);
        set_plan.push_back(SCORE_MIN);
        set_plan.push_back(32'sd3);
        set_plan.push_back(-Q_ONE);
        send_plan();

        // Directed: all scores equal, so every scan stops at once and swaps.
        steady = 1'b0;
        for (i = 0; i < 6; i++)
            set_plan.push_back(Q_ONE);
        send_plan();

        // Directed: rising scores, the worst order for a descending select.
        for (i = 1; i <= 8; i++)
            set_plan.push_back(i * Q_ONE);
        send_plan();

        // Store full: fill every RAM entry, then push a few more that must be
        // dropped, the last of them still closing the set.
        steady = 1'b1;
        for (i = 0; i < MAX_ITEMS + OVERFILL; i++)
            set_plan.push_back($urandom);
        send_plan();

        // Random sets: mostly TOP_COUNT..16 scores, some below TOP_COUNT, some
        // up to 64, each with one content shape.
        while (random_beats < RANDOM_BEATS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
                len = $urandom_range(1, TOP_COUNT - 1);
            else if (roll < 85)
                len = $urandom_range(TOP_COUNT, 16);
            else
                len = $urandom_range(17, 64);
            spread = score_spread_t'($urandom_range(0, 3));
            for (i = 0; i < len; i++)
            begin
                case (spread)
                    SPREAD_WIDE:   value = $urandom;
                    SPREAD_NARROW: value = int'($urandom_range(0, 8)) - 4;
                    SPREAD_EDGES:
                    begin
                        case ($urandom_range(0, 4))
                            0:       value = SCORE_MIN;
                            1:       value = SCORE_MAX;
                            2:       value = 32'sd0;
                            3:       value = -32'sd1;
                            default: value = $urandom;
                        endcase
                    end
                    default:       value = (int'($urandom_range(0, 3)) - 1) * Q_ONE;
                endcase
                set_plan.push_back(value);
            end
            steady = ($urandom_range(0, 9) < 3);
            send_plan();
            random_beats += len;
        end

        // Drop start, wait out the outstanding results, then watch for strays.
        @(negedge clk);
        start <= 1'b0;
        while (waiting_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d sets closed from %0d score beats, one set past a full store.",
                 sets_closed, beats_sent);
        $display("Run: %0d selected entries compared, %0d mismatches.",
                 checked_results, mismatch_count);
        if (mismatch_count == 0 && waiting_results == 0)
            $display("top_k_score_select_test OK");
        else
            $display("top_k_score_select_test NOT OK");
        $finish;
    end

    // Guard against a hang: far beyond the slowest plausible run.
    initial
    begin
        #(10_000_000);
        $display("Timeout: %0d results still expected", waiting_results);
        $display("top_k_score_select_test NOT OK");
        $finish;
    end

endmodule
